// ----- rtl/core/olt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants for the ordered list table
// Capacity, derived widths, command and status codes, cell control.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEAVES   = 1 << POS_W;
    localparam int LVL_W    = $clog2(POS_W + 1);

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REPLACE    = 3'd2,
        CMD_REMOVE_AT  = 3'd3,
        CMD_REMOVE_VAL = 3'd4,
        CMD_FIND       = 3'd5,
        CMD_GET        = 3'd6
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PROBE,
        OP_WRITE,
        OP_OPEN,
        OP_CLOSE
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [31:0]       data;
        logic              by_value;
        logic [CNT_W-1:0]  count;
    } cell_ctl_t;

    // search result travelling through the priority tree
    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  pos;
        logic [31:0]       val;
    } probe_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/olt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_cell: one list position
// Holds one entry, shifts from its neighbours and flags a probe match.
// ----------------------------------------------------------------------------
module olt_cell
    import olt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [POS_W-1:0]  cell_pos,
    input  wire cell_ctl_t         ctl,
    input  wire logic [31:0]       left_entry,
    input  wire logic [31:0]       right_entry,
    output logic      [31:0]       entry,
    output logic                   hit
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        hit_reg;
    logic        hit_next;
    logic        in_list;

    assign in_list = 32'(cell_pos) < 32'(ctl.count);

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        case (ctl.op)
            OP_PROBE:
            begin
                hit_next = ctl.by_value ? ((entry_reg == ctl.data) && in_list)
                                        : (cell_pos == ctl.pos);
            end
            OP_WRITE:
            begin
                if (cell_pos == ctl.pos)
                begin
                    entry_next = ctl.data;
                end
            end
            OP_OPEN:
            begin
                if (cell_pos > ctl.pos)
                begin
                    entry_next = left_entry;
                end
                else if (cell_pos == ctl.pos)
                begin
                    entry_next = ctl.data;
                end
            end
            OP_CLOSE:
            begin
                if (cell_pos >= ctl.pos)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry is payload: undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule
`default_nettype wire

// ----- rtl/core/olt_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_tree: registered first-match tree
// Picks the lowest flagged cell, one register level per tree level.
// ----------------------------------------------------------------------------
module olt_tree
    import olt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        leaf_hit [CAPACITY],
    input  wire logic [31:0] leaf_val [CAPACITY],
    output probe_res_t       root
);

    probe_res_t leaf_node [LEAVES];
    probe_res_t node_reg  [1:LEAVES-1];

    for (genvar j = 0; j < LEAVES; j++)
    begin : g_leaf
        if (j < CAPACITY)
        begin : g_real
            assign leaf_node[j] = '{hit: leaf_hit[j], pos: POS_W'(j), val: leaf_val[j]};
        end
        else
        begin : g_pad
            assign leaf_node[j] = '{hit: 1'b0, pos: POS_W'(j), val: 32'd0};
        end
    end

    // heap order: node k has children 2k and 2k+1; left wins
    for (genvar k = 1; k < LEAVES; k++)
    begin : g_node
        probe_res_t lo;
        probe_res_t hi;
        if (2 * k >= LEAVES)
        begin : g_from_leaf
            assign lo = leaf_node[2 * k - LEAVES];
            assign hi = leaf_node[2 * k + 1 - LEAVES];
        end
        else
        begin : g_from_node
            assign lo = node_reg[2 * k];
            assign hi = node_reg[2 * k + 1];
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= lo.hit ? lo : hi;
        end
    end

    assign root = node_reg[1];

endmodule
`default_nettype wire

// ----- rtl/core/ordered_list_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table: bounded ordered list of signed 32-bit values
// A row of entry cells with shift paths and a registered first-match tree.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, cmd,         | inbound
//          | value, index                     |
//  out     | out_valid, out_stall, status,    | outbound
//          | value_out, position, count       |
//
//  Each transaction passes through accept, a probe of all cells, the wait
//  through the registered match tree, then the update of the row; the
//  tree depth sets the length of the wait.
//  Reset clears the entry count and control; entry words are not cleared.
//  A result waits in the output register under out_stall while the next
//  transaction is accepted; the update stage holds until that register
//  is free.
// ----------------------------------------------------------------------------
module ordered_list_table
    import olt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [31:0] value,
    input  wire logic signed [15:0] index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      value_out,
    output logic [5:0]              position,
    output logic [6:0]              count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WAIT,
        S_APPLY
    } state_t;

    state_t             state_reg;
    logic [LVL_W-1:0]   wait_cnt_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [2:0]         cmd_reg;
    logic [31:0]        value_reg;
    logic [15:0]        index_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [31:0]        value_out_reg;
    logic [5:0]         position_reg;
    logic [6:0]         count_out_reg;

    // row of cells
    cell_ctl_t          ctl;
    logic [31:0]        cell_entry [CAPACITY];
    logic               cell_hit   [CAPACITY];
    probe_res_t         root;

    // decode of the held transaction
    logic               out_free;
    logic               full;
    logic               idx_neg;
    logic               in_range;
    logic               idx_past_end;
    logic [POS_W-1:0]   idx_pos;
    logic [POS_W-1:0]   ins_pos;
    logic               apply_ok;
    logic [1:0]         res_status;
    logic [31:0]        res_val;
    logic [POS_W-1:0]   res_pos;
    logic [CNT_W-1:0]   res_count;

    assign out_free     = !out_valid_reg || !out_stall;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign idx_neg      = index_reg[15];
    assign in_range     = !idx_neg && (32'(index_reg[14:0]) < 32'(count_reg));
    assign idx_past_end = !idx_neg && (32'(index_reg[14:0]) > 32'(count_reg));
    assign idx_pos      = index_reg[POS_W-1:0];

    // insert position, clamped to 0..count
    always_comb
    begin
        if ((cmd_t'(cmd_reg) == CMD_APPEND) || idx_past_end)
        begin
            ins_pos = count_reg[POS_W-1:0];
        end
        else if (idx_neg)
        begin
            ins_pos = '0;
        end
        else
        begin
            ins_pos = idx_pos;
        end
    end

    // result and row update for the held command
    always_comb
    begin
        res_status = ST_MISS;
        res_val    = 32'd0;
        res_pos    = '0;
        res_count  = count_reg;
        ctl.op       = OP_HOLD;
        ctl.pos      = idx_pos;
        ctl.data     = value_reg;
        ctl.by_value = (cmd_t'(cmd_reg) == CMD_REMOVE_VAL) || (cmd_t'(cmd_reg) == CMD_FIND);
        ctl.count    = count_reg;
        apply_ok     = 1'b0;

        unique case (cmd_t'(cmd_reg))
            CMD_APPEND, CMD_INSERT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status = ST_OK;
                    res_val    = value_reg;
                    res_pos    = ins_pos;
                    res_count  = count_reg + CNT_W'(1);
                    ctl.op     = OP_OPEN;
                    ctl.pos    = ins_pos;
                    apply_ok   = 1'b1;
                end
            end
            CMD_REPLACE:
            begin
                if (in_range)
                begin
                    res_status = ST_OK;
                    res_val    = value_reg;
                    res_pos    = idx_pos;
                    ctl.op     = OP_WRITE;
                    apply_ok   = 1'b1;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (in_range)
                begin
                    res_status = ST_OK;
                    res_val    = root.val;
                    res_pos    = idx_pos;
                    res_count  = count_reg - CNT_W'(1);
                    ctl.op     = OP_CLOSE;
                    apply_ok   = 1'b1;
                end
            end
            CMD_REMOVE_VAL:
            begin
                if (root.hit)
                begin
                    res_status = ST_OK;
                    res_val    = value_reg;
                    res_pos    = root.pos;
                    res_count  = count_reg - CNT_W'(1);
                    ctl.op     = OP_CLOSE;
                    ctl.pos    = root.pos;
                    apply_ok   = 1'b1;
                end
            end
            CMD_FIND:
            begin
                if (root.hit)
                begin
                    res_status = ST_OK;
                    res_val    = value_reg;
                    res_pos    = root.pos;
                end
            end
            CMD_GET:
            begin
                if (in_range)
                begin
                    res_status = ST_OK;
                    res_val    = root.val;
                    res_pos    = idx_pos;
                end
            end
            default:
            begin
                res_status = ST_MISS;
            end
        endcase

        // the row only moves in the probe cycle and in a committed update
        if (state_reg == S_PROBE)
        begin
            ctl.op  = OP_PROBE;
            ctl.pos = idx_pos;
        end
        else if (!((state_reg == S_APPLY) && out_free && apply_ok))
        begin
            ctl.op = OP_HOLD;
        end
    end

    // sequencer, held transaction and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_cnt_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a result taken outside the update cycle empties the register
            if (out_valid_reg && !out_stall && (state_reg != S_APPLY))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= cmd;
                        value_reg <= value;
                        index_reg <= index;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    wait_cnt_reg <= '0;
                    state_reg    <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (wait_cnt_reg == LVL_W'(POS_W - 1))
                    begin
                        state_reg <= S_APPLY;
                    end
                    else
                    begin
                        wait_cnt_reg <= wait_cnt_reg + LVL_W'(1);
                    end
                end
                S_APPLY:
                begin
                    if (out_free)
                    begin
                        status_reg    <= res_status;
                        value_out_reg <= res_val;
                        position_reg  <= 6'(res_pos);
                        count_out_reg <= 7'(res_count);
                        count_reg     <= res_count;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = 32'd0;
        end
        else
        begin : g_left
            assign left_w = cell_entry[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = 32'd0;
        end
        else
        begin : g_right
            assign right_w = cell_entry[i+1];
        end

        olt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_pos    (POS_W'(i)),
            .ctl         (ctl),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (cell_entry[i]),
            .hit         (cell_hit[i])
        );
    end

    olt_tree u_tree (
        .clk      (clk),
        .leaf_hit (cell_hit),
        .leaf_val (cell_entry),
        .root     (root)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign position  = position_reg;
    assign count     = count_out_reg;

endmodule
`default_nettype wire

// ----- rtl/core/olt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_checker: port-level checks for the ordered list table
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module olt_checker
    import olt_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic signed [31:0] value_out,
    input wire logic [5:0]         position,
    input wire logic [6:0]         count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
                                   && $stable(position) && $stable(count))
        else $error("result changed under stall");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_MISS) || (status == ST_FULL))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (value_out == 32'sd0) && (position == 6'd0))
        else $error("failed transaction carries data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == 7'(CAPACITY)))
        else $error("full reported below capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(count) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind ordered_list_table olt_checker u_olt_checker (.*);
`default_nettype wire
